### design/vdib_pkg.sv
`timescale 1ns / 1ps

package vdib_pkg;

   localparam int VIDX_W     = 12;
   localparam int OUT_IDX_W  = 12;
   localparam int SKIN_W     = 13;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // word index of each register (paddr[2])
   localparam logic REG_SKIN_WIDTH = 1'b0;

   localparam logic [SKIN_W-1:0] SKIN_WIDTH_RESET = 13'd256;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] out_index;
      logic                 is_new;
      logic                 overflow;
   } result_type;

endpackage

### design/vdib_ram.sv
`timescale 1ns / 1ps

module vdib_ram #(
   parameter int WIDTH = 37,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### design/vdib_seq.sv
`timescale 1ns / 1ps

module vdib_seq #(
   parameter int TABLE_DEPTH = 4096,
   parameter int COORD_BITS  = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           first_corner,
   input  logic [vdib_pkg::VIDX_W-1:0]    vertex_index,
   input  logic [COORD_BITS-1:0]          tex_s,
   input  logic [COORD_BITS-1:0]          tex_t,
   input  logic                           on_seam,
   input  logic                           faces_front,
   input  logic [vdib_pkg::SKIN_W-1:0]    skin_width,
   output logic                           res_valid,
   input  logic                           res_ready,
   output vdib_pkg::result_type           res
);

   localparam int S_W    = COORD_BITS + 1;
   localparam int ENT_W  = vdib_pkg::VIDX_W + S_W + COORD_BITS;
   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int HALF_W = vdib_pkg::SKIN_W - 1;
   localparam int SUM_W  = ((S_W > HALF_W) ? S_W : HALF_W) + 1;
   localparam int WIDE_W = vdib_pkg::OUT_IDX_W + IDX_W;

   function automatic logic [vdib_pkg::OUT_IDX_W-1:0] to_out(input logic [IDX_W-1:0] idx);
      logic [WIDE_W-1:0] wide;
      wide = {{vdib_pkg::OUT_IDX_W{1'b0}}, idx};
      return wide[vdib_pkg::OUT_IDX_W-1:0];
   endfunction

   vdib_pkg::seq_state_type state_ff, state_in;
   logic [ENT_W-1:0]        key_ff, key_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        limit_ff, limit_in;
   logic [CNT_W-1:0]        iss_ff, iss_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;
   vdib_pkg::result_type    res_ff, res_in;

   logic [HALF_W-1:0] half_width;
   logic [SUM_W-1:0]  s_sum;
   logic [S_W-1:0]    s_adj;
   logic [ENT_W-1:0]  key_new;
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [IDX_W-1:0]  ram_raddr;
   logic [ENT_W-1:0]  ram_rdata;
   logic              hit;
   logic              all_issued;
   logic              full;

   vdib_ram #(
      .WIDTH(ENT_W),
      .DEPTH(TABLE_DEPTH)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(key_ff),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // back-side seam corners move right by half the skin width
   assign half_width = skin_width[vdib_pkg::SKIN_W-1:1];
   assign s_sum      = SUM_W'(tex_s) + SUM_W'(half_width);
   assign s_adj      = (!faces_front && on_seam) ? s_sum[S_W-1:0] : S_W'(tex_s);
   assign key_new    = {vertex_index, s_adj, tex_t};

   assign hit        = cmp_vld_ff && (ram_rdata == key_ff);
   assign all_issued = (iss_ff == limit_ff);
   assign full       = (limit_ff == CNT_W'(TABLE_DEPTH));
   assign ram_raddr  = iss_ff[IDX_W-1:0];
   assign ram_waddr  = limit_ff[IDX_W-1:0];
   assign res        = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= vdib_pkg::ST_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
      end
      key_ff     <= key_in;
      limit_ff   <= limit_in;
      iss_ff     <= iss_in;
      cmp_idx_ff <= cmp_idx_in;
      res_ff     <= res_in;
   end

   always_comb begin
      state_in   = state_ff;
      key_in     = key_ff;
      count_in   = count_ff;
      limit_in   = limit_ff;
      iss_in     = iss_ff;
      cmp_vld_in = cmp_vld_ff;
      cmp_idx_in = cmp_idx_ff;
      res_in     = res_ff;
      req_ready  = 1'b0;
      res_valid  = 1'b0;
      ram_we     = 1'b0;

      unique case (state_ff)
         vdib_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in     = key_new;
               count_in   = first_corner ? '0 : count_ff;
               limit_in   = first_corner ? '0 : count_ff;
               iss_in     = '0;
               cmp_vld_in = 1'b0;
               state_in   = vdib_pkg::ST_SEARCH;
            end
         end
         vdib_pkg::ST_SEARCH: begin
            // compare the entry read last cycle while the next read goes out
            if (hit) begin
               res_in     = '{out_index: to_out(cmp_idx_ff), is_new: 1'b0, overflow: 1'b0};
               cmp_vld_in = 1'b0;
               state_in   = vdib_pkg::ST_DONE;
            end else if (all_issued) begin
               if (full) begin
                  res_in = '{out_index: '0, is_new: 1'b0, overflow: 1'b1};
               end else begin
                  ram_we   = 1'b1;
                  count_in = CNT_W'(limit_ff + 1'b1);
                  res_in   = '{out_index: to_out(limit_ff[IDX_W-1:0]),
                               is_new: 1'b1, overflow: 1'b0};
               end
               cmp_vld_in = 1'b0;
               state_in   = vdib_pkg::ST_DONE;
            end else begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = iss_ff[IDX_W-1:0];
               iss_in     = CNT_W'(iss_ff + 1'b1);
            end
         end
         vdib_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = vdib_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vdib_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### design/vertex_dedup_index_builder_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_ready   first_corner vertex_index tex_s tex_t
//                                            on_seam faces_front
// rsp_      out        rsp_valid/rsp_ready   out_index is_new overflow
// APB       in         psel/penable/pready   skin_width at byte address 0
//
// With n table entries (after a first-corner clear) the search reads up to n entries,
// one entry per cycle, and stops early on a match; the result then goes to the output
// register, and the next item is accepted once the sequencer is back in idle.
// req_ready is high only while the sequencer is idle. A result held by rsp_ready
// low stalls the sequencer at its final step once a second result is ready.
// Reset (synchronous) empties the table and sets skin_width to 256; the store is kept.

module vertex_dedup_index_builder_top #(
   parameter int TABLE_DEPTH = 4096,
   parameter int COORD_BITS  = 12
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_first_corner,
   input  logic [vdib_pkg::VIDX_W-1:0]         req_vertex_index,
   input  logic [COORD_BITS-1:0]               req_tex_s,
   input  logic [COORD_BITS-1:0]               req_tex_t,
   input  logic                                req_on_seam,
   input  logic                                req_faces_front,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [vdib_pkg::OUT_IDX_W-1:0]      rsp_out_index,
   output logic                                rsp_is_new,
   output logic                                rsp_overflow,

   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [vdib_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [vdib_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [vdib_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   logic [vdib_pkg::SKIN_W-1:0] skin_width_ff, skin_width_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   vdib_pkg::result_type        rsp_res_ff, rsp_res_in;

   logic                        res_valid;
   logic                        res_ready;
   vdib_pkg::result_type        res;
   logic                        csr_write;
   logic                        sel_skin;

   vdib_seq #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .COORD_BITS (COORD_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .first_corner(req_first_corner),
      .vertex_index(req_vertex_index),
      .tex_s       (req_tex_s),
      .tex_t       (req_tex_t),
      .on_seam     (req_on_seam),
      .faces_front (req_faces_front),
      .skin_width  (skin_width_ff),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign sel_skin  = (paddr[2] == vdib_pkg::REG_SKIN_WIDTH);

   always_comb begin
      prdata = '0;
      if (sel_skin) begin
         prdata = vdib_pkg::CSR_DATA_W'(skin_width_ff);
      end
   end

   // output register frees the sequencer when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      skin_width_in = skin_width_ff;
      if (csr_write && sel_skin) begin
         skin_width_in = pwdata[vdib_pkg::SKIN_W-1:0];
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skin_width_ff <= vdib_pkg::SKIN_WIDTH_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         skin_width_ff <= skin_width_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_res_ff.out_index;
   assign rsp_is_new    = rsp_res_ff.is_new;
   assign rsp_overflow  = rsp_res_ff.overflow;

endmodule

### bench/tb_vertex_dedup_index_builder_top.sv
`timescale 1ns / 1ps

module tb_vertex_dedup_index_builder_top;

   localparam int TB_DEPTH     = 4096;
   localparam int TB_COORD     = 12;
   localparam int LONG_MODEL   = 24;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int HOLD_CYCLES  = 250;

   localparam logic [vdib_pkg::CSR_ADDR_W-1:0] SKIN_ADDR = {vdib_pkg::REG_SKIN_WIDTH, 2'b00};

   typedef struct packed {
      logic [vdib_pkg::VIDX_W-1:0] vidx;
      logic [TB_COORD:0]           s_adj;
      logic [TB_COORD-1:0]         t;
   } weld_key_type;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic                              req_first_corner;
   logic [vdib_pkg::VIDX_W-1:0]       req_vertex_index;
   logic [TB_COORD-1:0]               req_tex_s;
   logic [TB_COORD-1:0]               req_tex_t;
   logic                              req_on_seam;
   logic                              req_faces_front;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [vdib_pkg::OUT_IDX_W-1:0]    rsp_out_index;
   logic                              rsp_is_new;
   logic                              rsp_overflow;
   logic                              psel;
   logic                              penable;
   logic                              pwrite;
   logic [vdib_pkg::CSR_ADDR_W-1:0]   paddr;
   logic [vdib_pkg::CSR_DATA_W-1:0]   pwdata;
   logic [vdib_pkg::CSR_DATA_W-1:0]   prdata;
   logic                              pready;

   // predictor state
   weld_key_type                      weld_table [TB_DEPTH];
   int                                weld_count;
   logic [vdib_pkg::SKIN_W-1:0]       cfg_skin_width;
   vdib_pkg::result_type              pending_results [$];

   bit                                sender_idle;
   bit                                receiver_idle;
   int                                hold_request;
   int                                cycle_count;
   int                                mismatches;
   int                                csr_errors;
   int                                corners_sent;
   int                                results_checked;
   int                                new_seen;
   int                                overflow_seen;
   int                                widths_used;

   vertex_dedup_index_builder_top #(
      .TABLE_DEPTH(TB_DEPTH),
      .COORD_BITS (TB_COORD)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_first_corner(req_first_corner),
      .req_vertex_index(req_vertex_index),
      .req_tex_s       (req_tex_s),
      .req_tex_t       (req_tex_t),
      .req_on_seam     (req_on_seam),
      .req_faces_front (req_faces_front),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_index   (rsp_out_index),
      .rsp_is_new      (rsp_is_new),
      .rsp_overflow    (rsp_overflow),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic vdib_pkg::result_type predict_corner(input bit first,
                                                           input logic [vdib_pkg::VIDX_W-1:0] vidx,
                                                           input logic [TB_COORD-1:0] s,
                                                           input logic [TB_COORD-1:0] t,
                                                           input bit seam, input bit front);
      weld_key_type         key;
      vdib_pkg::result_type res;
      begin
         if (first) weld_count = 0;
         key.vidx  = vidx;
         key.t     = t;
         key.s_adj = {1'b0, s};
         if (!front && seam) key.s_adj = key.s_adj + (cfg_skin_width >> 1);
         for (int i = 0; i < weld_count; i++) begin
            if (weld_table[i] == key) begin
               res.out_index = vdib_pkg::OUT_IDX_W'(i);
               res.is_new    = 1'b0;
               res.overflow  = 1'b0;
               return res;
            end
         end
         if (weld_count >= TB_DEPTH) begin
            res.out_index = '0;
            res.is_new    = 1'b0;
            res.overflow  = 1'b1;
            return res;
         end
         weld_table[weld_count] = key;
         res.out_index = vdib_pkg::OUT_IDX_W'(weld_count);
         res.is_new    = 1'b1;
         res.overflow  = 1'b0;
         weld_count++;
         return res;
      end
   endfunction

   // Offer one corner; return right after the accepting edge, valid still high
   // unless a gap was taken.
   task automatic send_corner(input bit first, input logic [vdib_pkg::VIDX_W-1:0] vidx,
                              input logic [TB_COORD-1:0] s, input logic [TB_COORD-1:0] t,
                              input bit seam, input bit front);
      logic rdy;
      int   gap;
      begin
         req_valid        <= 1'b1;
         req_first_corner <= first;
         req_vertex_index <= vidx;
         req_tex_s        <= s;
         req_tex_t        <= t;
         req_on_seam      <= seam;
         req_faces_front  <= front;
         do begin
            @(negedge clock);
            rdy = req_ready;
            @(posedge clock);
         end while (rdy !== 1'b1);
         pending_results.push_back(predict_corner(first, vidx, s, t, seam, front));
         corners_sent++;
         if (sender_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic stop_offering();
      req_valid <= 1'b0;
   endtask

   task automatic drain_results();
      stop_offering();
      while (pending_results.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_skin_width(input logic [vdib_pkg::SKIN_W-1:0] value);
      logic                            rdy;
      logic [vdib_pkg::CSR_DATA_W-1:0] rd;
      begin
         psel    <= 1'b1;
         penable <= 1'b0;
         pwrite  <= 1'b1;
         paddr   <= SKIN_ADDR;
         pwdata  <= vdib_pkg::CSR_DATA_W'(value);
         @(posedge clock);
         penable <= 1'b1;
         do begin
            @(negedge clock);
            rdy = pready;
            @(posedge clock);
         end while (rdy !== 1'b1);
         cfg_skin_width = value;
         widths_used++;
         // read back
         penable <= 1'b0;
         pwrite  <= 1'b0;
         @(posedge clock);
         penable <= 1'b1;
         do begin
            @(negedge clock);
            rdy = pready;
            rd  = prdata;
            @(posedge clock);
         end while (rdy !== 1'b1);
         psel    <= 1'b0;
         penable <= 1'b0;
         if (rd[vdib_pkg::SKIN_W-1:0] !== value) begin
            csr_errors++;
            if (mismatches + csr_errors <= 10)
               $display("skin_width readback: expected %0d, got %0d", value,
                        rd[vdib_pkg::SKIN_W-1:0]);
         end
      end
   endtask

   function automatic logic [11:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return 12'd0;
         1: return 12'd4095;
         default: return 12'($urandom());
      endcase
   endfunction

   task automatic test_basic_welding();
      begin
         send_corner(1, 12'd0, 12'd0, 12'd0, 0, 1);
         send_corner(0, 12'd0, 12'd0, 12'd0, 0, 1);
         send_corner(0, 12'd4095, 12'd4095, 12'd4095, 0, 1);
         send_corner(0, 12'd4095, 12'd4095, 12'd4095, 1, 0);
         send_corner(0, 12'd4095, 12'd4095, 12'd4095, 1, 1);
         send_corner(0, 12'd4095, 12'd4095, 12'd4095, 1, 0);
         send_corner(0, 12'd4095, 12'd4095, 12'd4095, 0, 0);
         send_corner(0, 12'd0, 12'd0, 12'd1, 0, 1);
         send_corner(0, 12'd1, 12'd0, 12'd0, 0, 1);
         // a new model forgets all earlier entries
         send_corner(1, 12'd4095, 12'd4095, 12'd4095, 0, 1);
         send_corner(0, 12'd0, 12'd0, 12'd0, 0, 1);
         drain_results();
      end
   endtask

   task automatic test_seam_offsets();
      logic [vdib_pkg::SKIN_W-1:0] widths [5];
      logic [11:0]                 half;
      begin
         widths = '{13'd1, 13'd2, 13'd3, 13'd4095, 13'd4096};
         foreach (widths[k]) begin
            write_skin_width(widths[k]);
            half = 12'(widths[k] >> 1);
            send_corner(1, 12'd7, 12'd100, 12'd9, 0, 1);
            send_corner(0, 12'd7, 12'd100, 12'd9, 1, 0);
            // front corner at the shifted s welds with the back seam corner
            send_corner(0, 12'd7, 12'd100 + half, 12'd9, 0, 1);
            send_corner(0, 12'd7, 12'd4095, 12'd4095, 1, 0);
            drain_results();
         end
      end
   endtask

   task automatic test_long_model();
      begin
         write_skin_width(13'd256);
         for (int i = 0; i < LONG_MODEL; i++)
            send_corner(i == 0, 12'(i), pick_coord(), pick_coord(),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         // early and late entries still match deep into the search
         send_corner(0, weld_table[5].vidx, weld_table[5].s_adj[11:0], weld_table[5].t,
                     weld_table[5].s_adj[12], 1);
         send_corner(0, 12'd4000, 12'd1, 12'd2, 0, 1);
         send_corner(0, 12'd4001, 12'd4095, 12'd4095, 1, 0);
         send_corner(0, 12'(LONG_MODEL - 1), weld_table[LONG_MODEL-1].s_adj[11:0],
                     weld_table[LONG_MODEL-1].t, 0, 1);
         send_corner(1, 12'd4001, 12'd4095, 12'd4095, 1, 0);
         drain_results();
      end
   endtask

   task automatic test_output_stall();
      begin
         sender_idle  = 1'b0;
         hold_request = HOLD_CYCLES;
         for (int i = 0; i < 8; i++)
            send_corner(i == 0, 12'($urandom_range(0, 3)), 12'($urandom()), 12'd5, 0, 1);
         drain_results();
      end
   endtask

   task automatic test_random_models(input int n_items);
      logic [11:0] pool_vidx [16];
      logic [11:0] pool_s    [16];
      logic [11:0] pool_t    [16];
      bit          pool_seam [16];
      int          sent;
      int          model_len;
      int          pool_size;
      int          p;
      begin
         sent = 0;
         while (sent < n_items) begin
            model_len = $urandom_range(3, 40);
            pool_size = $urandom_range(2, 16);
            for (int j = 0; j < pool_size; j++) begin
               pool_vidx[j] = pick_coord();
               pool_s[j]    = pick_coord();
               pool_t[j]    = pick_coord();
               pool_seam[j] = 1'($urandom_range(0, 1));
            end
            for (int k = 0; k < model_len && sent < n_items; k++) begin
               if ($urandom_range(0, 6) == 0) begin
                  // noise corner; now and then it also restarts the model
                  send_corner(k == 0 || $urandom_range(0, 9) == 0, pick_coord(), pick_coord(),
                              pick_coord(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
               end else begin
                  p = $urandom_range(0, pool_size - 1);
                  send_corner(k == 0, pool_vidx[p], pool_s[p], pool_t[p], pool_seam[p],
                              1'($urandom_range(0, 1)));
               end
               sent++;
            end
         end
         drain_results();
      end
   endtask

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      int stall_left;
      int hold_left;
      bit hold_taken;
      stall_left = 0;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_taken && hold_request > 0) begin
            hold_left  = hold_request;
            hold_taken = 1'b1;
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (receiver_idle && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // result checker
   initial begin
      logic                 v;
      logic                 r;
      vdib_pkg::result_type got;
      vdib_pkg::result_type want;
      mismatches      = 0;
      results_checked = 0;
      new_seen        = 0;
      overflow_seen   = 0;
      forever begin
         @(negedge clock);
         v = rsp_valid;
         r = rsp_ready;
         got.out_index = rsp_out_index;
         got.is_new    = rsp_is_new;
         got.overflow  = rsp_overflow;
         @(posedge clock);
         if (!reset && v === 1'b1 && r === 1'b1) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches + csr_errors <= 10)
                  $display("unexpected result: index %0d new %0b overflow %0b",
                           got.out_index, got.is_new, got.overflow);
            end else begin
               want = pending_results.pop_front();
               results_checked++;
               if (want.is_new) new_seen++;
               if (want.overflow) overflow_seen++;
               if (got.out_index !== want.out_index || got.is_new !== want.is_new ||
                   got.overflow !== want.overflow) begin
                  mismatches++;
                  if (mismatches + csr_errors <= 10)
                     $display("result %0d: want idx %0d new %0b ovf %0b, got %0d %0b %0b",
                              results_checked, want.out_index, want.is_new, want.overflow,
                              got.out_index, got.is_new, got.overflow);
               end
            end
         end
      end
   end

   // timeout
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_vertex_dedup_index_builder_top NOT OK");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_first_corner = 1'b0;
      req_vertex_index = '0;
      req_tex_s        = '0;
      req_tex_t        = '0;
      req_on_seam      = 1'b0;
      req_faces_front  = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      weld_count       = 0;
      cfg_skin_width   = vdib_pkg::SKIN_WIDTH_RESET;
      sender_idle      = 1'b1;
      receiver_idle    = 1'b1;
      hold_request     = 0;
      csr_errors       = 0;
      corners_sent     = 0;
      widths_used      = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_welding();
      test_seam_offsets();
      test_long_model();
      test_output_stall();
      sender_idle = 1'b1;
      for (int ph = 0; ph < 4; ph++) begin
         write_skin_width(13'($urandom_range(1, 4096)));
         if (ph == 3) begin
            // no idling in the closing phase
            sender_idle   = 1'b0;
            receiver_idle = 1'b0;
         end
         test_random_models(20);
      end

      while (pending_results.size() > 0) @(posedge clock);
      repeat (TB_DEPTH + 8) @(posedge clock);

      $display("Sent %0d corners across %0d skin width settings; %0d results checked.",
               corners_sent, widths_used, results_checked);
      $display("Entries appended: %0d, overflow results: %0d, mismatches: %0d.",
               new_seen, overflow_seen, mismatches + csr_errors);
      if (mismatches == 0 && csr_errors == 0 && pending_results.size() == 0) begin
         $display("tb_vertex_dedup_index_builder_top OK");
      end else begin
         $display("tb_vertex_dedup_index_builder_top NOT OK");
      end
      $finish;
   end

endmodule

### vertex_dedup_index_builder_top.f
design/vdib_pkg.sv
design/vdib_ram.sv
design/vdib_seq.sv
design/vertex_dedup_index_builder_top.sv
bench/tb_vertex_dedup_index_builder_top.sv
